// File: rtl/serial_response_matcher_macros.svh
// ----------------------------------------------------------------------------
// Serial response matcher assertion macros
// Shorthand for clocked assertions on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SERIAL_RESPONSE_MATCHER_MACROS_SVH
`define SERIAL_RESPONSE_MATCHER_MACROS_SVH

// same-cycle implication
`define SRM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types, codes and sizes of the serial response matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

  localparam int PATTERN_MAX   = 16;
  localparam int CAPTURE_DEPTH = 256;
  localparam int CAP_AW        = $clog2(CAPTURE_DEPTH);

  localparam logic [19:0] TICK_MAX = 20'hFFFFF;

  // commands
  localparam logic [2:0] CMD_CHAR  = 3'd0;
  localparam logic [2:0] CMD_TICK  = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // step modes
  localparam logic [1:0] MODE_MATCH     = 2'd0;
  localparam logic [1:0] MODE_TIMEOUT   = 2'd1;
  localparam logic [1:0] MODE_IMMEDIATE = 2'd2;
  localparam logic [1:0] MODE_INVALID   = 2'd3;

  // step status
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  // register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [2:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd3;
  localparam logic [2:0] REG_CAPTURE_LIMIT  = 3'd4;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [4:0]  pattern_length;
    logic [19:0] timeout_ticks;
    logic [8:0]  capture_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] rx_char;
    logic [1:0] step_mode;
    logic       capture_request;
    logic [7:0] read_index;
  } item_t;

  typedef struct packed {
    logic [1:0] step_status;
    logic [8:0] captured_count;
    logic [7:0] read_data;
    logic       listening;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [CAP_AW-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

endpackage

`default_nettype wire

// File: rtl/srm_ram.sv
// ----------------------------------------------------------------------------
// srm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/srm_cfg.sv
// ----------------------------------------------------------------------------
// srm_cfg
// APB register file: pattern, pattern length, timeout and capture limit.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [5:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output      logic [63:0]   prdata,
  output      logic          pready,
  output      srm_pkg::cfg_t cfg
);
  import srm_pkg::*;

  logic       wr;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.pattern_length <= 5'd1;
      cfg.timeout_ticks  <= '0;
      cfg.capture_limit  <= 9'(CAPTURE_DEPTH);
    end else if (wr) begin
      case (reg_sel)
        REG_PATTERN_LOW:    cfg.pattern_low    <= pwdata;
        REG_PATTERN_HIGH:   cfg.pattern_high   <= pwdata;
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[4:0];
        REG_TIMEOUT_TICKS:  cfg.timeout_ticks  <= pwdata[19:0];
        REG_CAPTURE_LIMIT:  cfg.capture_limit  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PATTERN_LOW:    prdata = cfg.pattern_low;
      REG_PATTERN_HIGH:   prdata = cfg.pattern_high;
      REG_PATTERN_LENGTH: prdata = {59'd0, cfg.pattern_length};
      REG_TIMEOUT_TICKS:  prdata = {44'd0, cfg.timeout_ticks};
      REG_CAPTURE_LIMIT:  prdata = {55'd0, cfg.capture_limit};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/srm_core.sv
// ----------------------------------------------------------------------------
// srm_core
// Step state, matcher, capture control and tick timer; one item per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire srm_pkg::item_t    item,
  input  wire srm_pkg::cfg_t     cfg,
  input  wire logic [7:0]        rd_char,
  output      srm_pkg::result_t  result,
  output      srm_pkg::store_wr_t store_wr
);
  import srm_pkg::*;

  logic [4:0]  match_index, match_index_next;
  logic        matcher_armed, matcher_armed_next;
  logic        capture_on, capture_on_next;
  logic [8:0]  capture_count, capture_count_next;
  logic        step_waiting, step_waiting_next;
  logic        wait_is_timeout_only, wait_is_timeout_only_next;
  logic [19:0] ticks_elapsed, ticks_elapsed_next;

  logic [127:0] pattern;
  logic [7:0]   cur_char;
  logic [4:0]   eff_len;
  logic [8:0]   eff_limit;
  logic [4:0]   index_inc;
  logic [19:0]  ticks_inc;
  logic         matched;
  logic         cap_write;
  logic [1:0]   idle_status;
  logic [1:0]   status;
  logic [7:0]   rdata;

  assign pattern     = {cfg.pattern_high, cfg.pattern_low};
  assign cur_char    = pattern[match_index[3:0]*8 +: 8];
  assign index_inc   = match_index + 5'd1;
  assign ticks_inc   = (ticks_elapsed == TICK_MAX) ? ticks_elapsed : ticks_elapsed + 20'd1;
  assign idle_status = step_waiting ? ST_WAIT : ST_NONE;

  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      eff_len = 5'd1;
    end else if (cfg.pattern_length > 5'(PATTERN_MAX)) begin
      eff_len = 5'(PATTERN_MAX);
    end else begin
      eff_len = cfg.pattern_length;
    end
    eff_limit = (cfg.capture_limit > 9'(CAPTURE_DEPTH)) ? 9'(CAPTURE_DEPTH)
                                                         : cfg.capture_limit;
  end

  always_comb begin
    match_index_next          = match_index;
    matcher_armed_next        = matcher_armed;
    capture_on_next           = capture_on;
    capture_count_next        = capture_count;
    step_waiting_next         = step_waiting;
    wait_is_timeout_only_next = wait_is_timeout_only;
    ticks_elapsed_next        = ticks_elapsed;
    matched                   = 1'b0;
    cap_write                 = 1'b0;
    status                    = idle_status;
    rdata                     = '0;

    case (item.cmd)
      CMD_CHAR: begin
        if (matcher_armed) begin
          if (cur_char == item.rx_char) begin
            match_index_next = index_inc;
            matched          = (index_inc >= eff_len);
          end else begin
            match_index_next = (pattern[7:0] == item.rx_char) ? 5'd1 : 5'd0;
          end
        end
        if (capture_on) begin
          if (capture_count >= eff_limit) begin
            capture_on_next = 1'b0;
          end else begin
            cap_write          = 1'b1;
            capture_count_next = capture_count + 9'd1;
          end
        end
        if (matched) begin
          matcher_armed_next = 1'b0;
          match_index_next   = '0;
          step_waiting_next  = 1'b0;
          capture_on_next    = 1'b0;
          status             = ST_OK;
        end
      end
      CMD_TICK: begin
        if (step_waiting && (cfg.timeout_ticks != '0)) begin
          ticks_elapsed_next = ticks_inc;
          if (ticks_inc >= cfg.timeout_ticks) begin
            status             = wait_is_timeout_only ? ST_OK : ST_FAIL;
            step_waiting_next  = 1'b0;
            matcher_armed_next = 1'b0;
            match_index_next   = '0;
            capture_on_next    = 1'b0;
          end else begin
            status = ST_WAIT;
          end
        end
      end
      CMD_START: begin
        if (item.step_mode == MODE_INVALID) begin
          status = ST_FAIL;
        end else begin
          ticks_elapsed_next        = '0;
          match_index_next          = '0;
          capture_on_next           = item.capture_request;
          matcher_armed_next        = (item.step_mode == MODE_MATCH);
          step_waiting_next         = (item.step_mode != MODE_IMMEDIATE);
          wait_is_timeout_only_next = (item.step_mode == MODE_TIMEOUT);
          status = (item.step_mode == MODE_IMMEDIATE) ? ST_OK : ST_WAIT;
        end
      end
      CMD_CLEAR: begin
        // entries at or above the count are never read, so no sweep is needed
        capture_count_next = '0;
      end
      CMD_READ: begin
        if ({1'b0, item.read_index} < capture_count) begin
          rdata = rd_char;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_index          <= '0;
      matcher_armed        <= 1'b0;
      capture_on           <= 1'b0;
      capture_count        <= '0;
      step_waiting         <= 1'b0;
      wait_is_timeout_only <= 1'b0;
      ticks_elapsed        <= '0;
    end else if (advance) begin
      match_index          <= match_index_next;
      matcher_armed        <= matcher_armed_next;
      capture_on           <= capture_on_next;
      capture_count        <= capture_count_next;
      step_waiting         <= step_waiting_next;
      wait_is_timeout_only <= wait_is_timeout_only_next;
      ticks_elapsed        <= ticks_elapsed_next;
    end
  end

  assign store_wr.en   = advance & cap_write;
  assign store_wr.addr = capture_count[CAP_AW-1:0];
  assign store_wr.data = item.rx_char;

  assign result.step_status    = status;
  assign result.captured_count = capture_count_next;
  assign result.read_data      = rdata;
  assign result.listening      = matcher_armed_next | capture_on_next;

endmodule

`default_nettype wire

// File: rtl/serial_response_matcher.sv
// ----------------------------------------------------------------------------
// serial_response_matcher
// Matches received characters against a configured response string, times
// out steps on ticks and captures received characters into a store.
// ----------------------------------------------------------------------------
//
//   Channel  Ports            Direction  Payload
//   s_*      tvalid/tready    in         tuser: cmd; tdata: char, mode, capture, index
//   m_*      tvalid/tready    out        tdata: status, count, read data, listening
//   APB      psel..pready     in         five registers at byte address 8*index
//
// One item per cycle sustained while the result side does not stall; a
// result passes through the input register, then the result register,
// before it is offered.
// The capture store read is issued at the input transfer, with a bypass
// for a write made in that same cycle.
// A stalled result holds the result register and the input register; the
// input side keeps accepting while either register has room.
// Reset clears all control state at once; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_response_matcher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,  // rx_char[7:0], step_mode[9:8],
                                     // capture_request[10], read_index[18:11]
  input  wire logic [2:0]  s_tuser,  // cmd[2:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,  // step_status[1:0], captured_count[10:2],
                                     // read_data[18:11], listening[19]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output      logic [63:0] prdata,
  output      logic        pready
);
  import srm_pkg::*;

  cfg_t      cfg;
  item_t     s_item;
  item_t     in_item;
  logic      in_valid;
  logic      accept;
  logic      advance;
  logic      bypass_hit;
  logic [7:0] bypass_data;
  logic [7:0] ram_rdata;
  logic [7:0] rd_char;
  result_t   result;
  store_wr_t store_wr;

  assign s_item.cmd             = s_tuser;
  assign s_item.rx_char         = s_tdata[7:0];
  assign s_item.step_mode       = s_tdata[9:8];
  assign s_item.capture_request = s_tdata[10];
  assign s_item.read_index      = s_tdata[18:11];

  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  srm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srm_ram #(
    .WIDTH (8),
    .DEPTH (CAPTURE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_wr.en),
    .waddr (store_wr.addr),
    .wdata (store_wr.data),
    .re    (accept),
    .raddr (s_item.read_index[CAP_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      bypass_hit <= 1'b0;
    end else begin
      if (accept) begin
        in_valid   <= 1'b1;
        // the item in flight writes the slot this read is fetching
        bypass_hit <= store_wr.en && (store_wr.addr == s_item.read_index[CAP_AW-1:0]);
      end else if (advance) begin
        in_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item     <= s_item;
      bypass_data <= store_wr.data;
    end
  end

  assign rd_char = bypass_hit ? bypass_data : ram_rdata;

  srm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (in_item),
    .cfg      (cfg),
    .rd_char  (rd_char),
    .result   (result),
    .store_wr (store_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, result.listening, result.read_data,
                  result.captured_count, result.step_status};
    end
  end

endmodule

`default_nettype wire

// File: rtl/srm_checker.sv
// ----------------------------------------------------------------------------
// srm_checker
// Port-level checks on the serial response matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_response_matcher_macros.svh"

module srm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);
  import srm_pkg::*;

  // a stalled result holds
  `SRM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
    "stalled result changed")

  // with no result pending the input side must take a transfer
  `SRM_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready,
    "input stalled while output empty")

  `SRM_ASSERT_IMP(a_count_range, m_tvalid, m_tdata[10:2] <= 9'(CAPTURE_DEPTH),
    "captured count beyond store depth")

  // stored data can only come back from a non-empty store
  `SRM_ASSERT_IMP(a_read_needs_count, m_tvalid && (m_tdata[18:11] != 8'd0),
    m_tdata[10:2] != 9'd0, "read data with empty store")

endmodule

bind serial_response_matcher srm_checker u_srm_checker (.*);

`default_nettype wire

// File: test/serial_response_matcher_tb.sv
// ----------------------------------------------------------------------------
// serial_response_matcher_tb
// Self-checking regression for the serial response matcher. Directed items
// exercise every command and step mode, pattern restarts, timeouts, capture
// limits and a pattern length cut short mid-match. Random traffic under
// several pattern, timeout and limit settings then follows. A model in the
// bench predicts each result, and the bench compares it field by field
// with the block's output.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_response_matcher_tb;

  import srm_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // rx_char[7:0], step_mode[9:8],
                               // capture_request[10], read_index[18:11]
  logic [2:0]  s_tuser = '0;   // cmd[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // step_status[1:0], captured_count[10:2],
                               // read_data[18:11], listening[19]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  serial_response_matcher uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // matcher model: configuration
  logic [127:0] response_pattern;
  logic [4:0]   pattern_len_reg;
  logic [19:0]  timeout_reg;
  logic [8:0]   capture_limit_reg;

  // matcher model: state
  logic [4:0]  match_idx;
  logic        armed;
  logic        cap_on;
  logic [8:0]  cap_count;
  logic [7:0]  cap_store [CAPTURE_DEPTH];
  logic        waiting;
  logic        timer_only_step;
  logic [19:0] ticks;

  result_t expected_responses [$];
  result_t seen;
  result_t wanted;

  int mismatches = 0;
  int items_sent = 0;
  int valid_idle_pct = 0;
  int ready_stall_pct = 0;
  int hold_off_left = 0;
  int quiet_cycles = 0;

  function automatic logic [7:0] pattern_char(input logic [4:0] k);
    return response_pattern[8 * k[3:0] +: 8];
  endfunction

  function automatic item_t make_item(input logic [2:0] cmd, input logic [7:0] ch,
                                      input logic [1:0] mode, input logic req,
                                      input logic [7:0] idx);
    item_t it;
    it.cmd = cmd;
    it.rx_char = ch;
    it.step_mode = mode;
    it.capture_request = req;
    it.read_index = idx;
    return it;
  endfunction

  // store position, mostly one that holds a captured character
  function automatic logic [7:0] read_spot();
    if (cap_count == 0 || $urandom_range(3) == 0)
      return 8'($urandom);
    return 8'($urandom_range(cap_count - 1));
  endfunction

  function automatic item_t random_item();
    return make_item(3'($urandom_range(7)), 8'($urandom), 2'($urandom), 1'($urandom),
                     read_spot());
  endfunction

  // expected result of one item; advances the model state
  task automatic matcher_response(input item_t it, output result_t r);
    logic       matched;
    logic [4:0] eff_len;
    logic [8:0] eff_lim;
    logic [1:0] status;
    logic [7:0] rdata;
    matched = 1'b0;
    rdata = '0;
    eff_len = (pattern_len_reg == 0) ? 5'd1 :
              (pattern_len_reg > PATTERN_MAX) ? 5'(PATTERN_MAX) : pattern_len_reg;
    eff_lim = (capture_limit_reg > CAPTURE_DEPTH) ? 9'(CAPTURE_DEPTH) : capture_limit_reg;
    status = waiting ? ST_WAIT : ST_NONE;
    case (it.cmd)
      CMD_CHAR: begin
        if (armed) begin
          if (pattern_char(match_idx) == it.rx_char) begin
            match_idx = match_idx + 5'd1;
            matched = (match_idx >= eff_len);
          end else begin
            match_idx = (pattern_char(5'd0) == it.rx_char) ? 5'd1 : 5'd0;
          end
        end
        if (cap_on) begin
          if (cap_count >= eff_lim) begin
            cap_on = 1'b0;
          end else begin
            cap_store[cap_count[7:0]] = it.rx_char;
            cap_count = cap_count + 9'd1;
          end
        end
        if (matched) begin
          armed = 1'b0;
          match_idx = '0;
          waiting = 1'b0;
          cap_on = 1'b0;
          status = ST_OK;
        end
      end
      CMD_TICK: begin
        if (waiting && timeout_reg != 0) begin
          if (ticks < TICK_MAX)
            ticks = ticks + 20'd1;
          if (ticks >= timeout_reg) begin
            status = timer_only_step ? ST_OK : ST_FAIL;
            waiting = 1'b0;
            armed = 1'b0;
            match_idx = '0;
            cap_on = 1'b0;
          end
        end
      end
      CMD_START: begin
        if (it.step_mode == MODE_INVALID) begin
          status = ST_FAIL;
        end else begin
          ticks = '0;
          match_idx = '0;
          cap_on = it.capture_request;
          armed = (it.step_mode == MODE_MATCH);
          waiting = (it.step_mode != MODE_IMMEDIATE);
          timer_only_step = (it.step_mode == MODE_TIMEOUT);
          status = (it.step_mode == MODE_IMMEDIATE) ? ST_OK : ST_WAIT;
        end
      end
      CMD_CLEAR: begin
        cap_count = '0;
      end
      CMD_READ: begin
        if ({1'b0, it.read_index} < cap_count)
          rdata = cap_store[it.read_index];
      end
      default: begin
      end
    endcase
    r.step_status = status;
    r.captured_count = cap_count;
    r.read_data = rdata;
    r.listening = armed | cap_on;
  endtask

  task automatic reset_model();
    response_pattern = '0;
    pattern_len_reg = 5'd1;
    timeout_reg = '0;
    capture_limit_reg = 9'd256;
    match_idx = '0;
    armed = 1'b0;
    cap_on = 1'b0;
    cap_count = '0;
    waiting = 1'b0;
    timer_only_step = 1'b0;
    ticks = '0;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:    response_pattern[63:0] = value;
      REG_PATTERN_HIGH:   response_pattern[127:64] = value;
      REG_PATTERN_LENGTH: pattern_len_reg = value[4:0];
      REG_TIMEOUT_TICKS:  timeout_reg = value[19:0];
      REG_CAPTURE_LIMIT:  capture_limit_reg = value[8:0];
      default: begin
      end
    endcase
  endtask

  // offer one item; returns right after its transfer with tvalid still high
  task automatic send_item(input item_t it);
    result_t r;
    while ($urandom_range(99) < valid_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, it.read_index, it.capture_request, it.step_mode, it.rx_char};
    s_tuser <= it.cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    matcher_response(it, r);
    expected_responses.push_back(r);
    if (it.cmd <= CMD_READ)
      items_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic randomize_setup();
    logic [127:0] pat;
    logic         narrow;
    logic [4:0]   len;
    logic [19:0]  tmo;
    logic [8:0]   lim;
    int           k;
    narrow = 1'($urandom_range(1));
    for (k = 0; k < 16; k++)
      pat[8 * k +: 8] = narrow ? 8'(8'h41 + $urandom_range(1)) : 8'($urandom);
    case ($urandom_range(7))
      0: pat = '0;
      1: pat = '1;
      default: begin
      end
    endcase
    case ($urandom_range(9))
      0: len = 5'd0;
      1: len = 5'd16;
      2: len = 5'd31;
      3: len = 5'($urandom_range(7, 20));
      default: len = 5'($urandom_range(1, 6));
    endcase
    case ($urandom_range(5))
      0: tmo = '0;
      1: tmo = 20'd1;
      2: tmo = 20'hFFFFF;
      default: tmo = 20'($urandom_range(2, 12));
    endcase
    case ($urandom_range(5))
      0: lim = 9'd0;
      1: lim = 9'd1;
      2: lim = 9'd256;
      3: lim = 9'd511;
      default: lim = 9'($urandom_range(2, 40));
    endcase
    write_register(REG_PATTERN_LOW, pat[63:0]);
    write_register(REG_PATTERN_HIGH, pat[127:64]);
    write_register(REG_PATTERN_LENGTH, {59'b0, len});
    write_register(REG_TIMEOUT_TICKS, {44'b0, tmo});
    write_register(REG_CAPTURE_LIMIT, {55'b0, lim});
  endtask

  // mostly start-then-respond exchanges, the rest noise
  task automatic run_traffic(input int quota);
    int stop_at;
    int span;
    int k;
    int roll;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 65) begin
        send_item(make_item(CMD_START, 8'($urandom),
                            ($urandom_range(3) == 0) ? MODE_TIMEOUT : MODE_MATCH,
                            1'($urandom), 8'($urandom)));
        span = $urandom_range(1, 24);
        for (k = 0; k < span; k++) begin
          roll = $urandom_range(99);
          if (roll < 65)
            send_item(make_item(CMD_CHAR, pattern_char(match_idx), 2'($urandom),
                                1'($urandom), 8'($urandom)));
          else if (roll < 72)
            send_item(make_item(CMD_CHAR, pattern_char(5'd0), 2'($urandom), 1'($urandom),
                                8'($urandom)));
          else if (roll < 80)
            send_item(make_item(CMD_CHAR, 8'($urandom), 2'($urandom), 1'($urandom),
                                8'($urandom)));
          else if (roll < 90)
            send_item(make_item(CMD_TICK, 8'($urandom), 2'($urandom), 1'($urandom),
                                8'($urandom)));
          else if (roll < 95)
            send_item(make_item(CMD_READ, 8'($urandom), 2'($urandom), 1'($urandom),
                                read_spot()));
          else
            send_item(random_item());
        end
      end else begin
        send_item(random_item());
      end
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
    int round;
    valid_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    for (round = 0; round < 3; round++) begin
      drain_results();
      randomize_setup();
      run_traffic(quota / 3);
    end
    drain_results();
  endtask

  task automatic test_step_modes();
    write_register(REG_PATTERN_LOW, '1);
    write_register(REG_PATTERN_HIGH, '0);
    write_register(REG_PATTERN_LENGTH, 64'd16);
    write_register(REG_TIMEOUT_TICKS, 64'hFFFFF);
    write_register(REG_CAPTURE_LIMIT, 64'd256);
    send_item(make_item(CMD_START, 8'h00, MODE_INVALID, 1'b1, 8'h00));
    send_item(make_item(CMD_START, 8'h00, MODE_IMMEDIATE, 1'b1, 8'h00));
    send_item(make_item(CMD_CHAR, 8'hFF, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_READ, 8'h00, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_READ, 8'h00, 2'b00, 1'b0, 8'hFF));
    send_item(make_item(3'd7, 8'hFF, 2'b11, 1'b1, 8'hFF));
    send_item(make_item(CMD_CLEAR, 8'h00, 2'b00, 1'b0, 8'h00));
    drain_results();
  endtask

  // a repeated first character must restart the match at one, not zero
  task automatic test_match_restart();
    write_register(REG_PATTERN_LOW, 64'h0000_0000_0042_4141);
    write_register(REG_PATTERN_LENGTH, 64'd3);
    send_item(make_item(CMD_START, 8'h00, MODE_MATCH, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h41, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h41, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h41, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h00, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h41, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h41, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h42, 2'b00, 1'b0, 8'h00));
    drain_results();
  endtask

  task automatic test_timeouts();
    write_register(REG_TIMEOUT_TICKS, 64'd2);
    send_item(make_item(CMD_START, 8'h00, MODE_TIMEOUT, 1'b0, 8'h00));
    send_item(make_item(CMD_TICK, 8'h00, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_TICK, 8'h00, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_START, 8'h00, MODE_MATCH, 1'b1, 8'h00));
    send_item(make_item(CMD_TICK, 8'h00, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_TICK, 8'h00, 2'b00, 1'b0, 8'h00));
    drain_results();
  endtask

  task automatic test_capture_limits();
    write_register(REG_CAPTURE_LIMIT, 64'd0);
    send_item(make_item(CMD_START, 8'h00, MODE_IMMEDIATE, 1'b1, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h5A, 2'b00, 1'b0, 8'h00));
    drain_results();
    write_register(REG_CAPTURE_LIMIT, 64'd1);
    send_item(make_item(CMD_START, 8'h00, MODE_IMMEDIATE, 1'b1, 8'h00));
    send_item(make_item(CMD_CHAR, 8'hA5, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h3C, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_READ, 8'h00, 2'b00, 1'b0, 8'h00));
    drain_results();
    write_register(REG_CAPTURE_LIMIT, 64'd511);
  endtask

  // shrink the length under an armed match: the next hit completes it
  task automatic test_length_shrink();
    write_register(REG_PATTERN_LOW, 64'h0000_0000_4443_4241);
    write_register(REG_PATTERN_LENGTH, 64'd4);
    send_item(make_item(CMD_START, 8'h00, MODE_MATCH, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h41, 2'b00, 1'b0, 8'h00));
    send_item(make_item(CMD_CHAR, 8'h42, 2'b00, 1'b0, 8'h00));
    drain_results();
    write_register(REG_PATTERN_LENGTH, 64'd0);
    send_item(make_item(CMD_CHAR, 8'h43, 2'b00, 1'b0, 8'h00));
    drain_results();
  endtask

  task automatic test_steady_traffic();
    run_phase(0, 0, 120);
  endtask

  task automatic test_sender_gaps();
    run_phase(64, 0, 90);
  endtask

  task automatic test_receiver_stalls();
    run_phase(0, 64, 90);
  endtask

  task automatic test_mixed_gaps();
    run_phase(14, 14, 120);
  endtask

  // hold the result side off long enough for the block to stall its input
  task automatic test_backpressure();
    valid_idle_pct = 0;
    ready_stall_pct = 0;
    randomize_setup();
    hold_off_left = 300;
    run_traffic(40);
    drain_results();
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // result side: check each transfer, then drive tready for the next edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.step_status = m_tdata[1:0];
      seen.captured_count = m_tdata[10:2];
      seen.read_data = m_tdata[18:11];
      seen.listening = m_tdata[19];
      if (expected_responses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
      end else begin
        wanted = expected_responses.pop_front();
        check_field("step_status", int'(wanted.step_status), int'(seen.step_status));
        check_field("captured_count", int'(wanted.captured_count),
                    int'(seen.captured_count));
        check_field("read_data", int'(wanted.read_data), int'(seen.read_data));
        check_field("listening", int'(wanted.listening), int'(seen.listening));
      end
    end
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("serial_response_matcher regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_step_modes();
    test_match_restart();
    test_timeouts();
    test_capture_limits();
    test_length_shrink();
    test_steady_traffic();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_backpressure();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_responses.size() == 0)
      $display("serial_response_matcher regression: pass");
    else
      $display("serial_response_matcher regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
